@@ src/wsdf_pkg.sv @@
// Shared types, constants and helpers for the WebSocket frame deframer.
package wsdf_pkg;

    localparam int LENGTH_BITS_DEF = 64;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0] LEN7_EXT16 = 8'd126;
    localparam logic [7:0] LEN7_EXT64 = 8'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [3:0] KEY_BYTES = 4'd4;

    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING = 4'h9;

    typedef enum logic [1:0] {
        KIND_TEXT  = 2'd0,
        KIND_CLOSE = 2'd1,
        KIND_PING  = 2'd2,
        KIND_OTHER = 2'd3
    } frame_kind_t;

    typedef enum logic [2:0] {
        PH_HDR0 = 3'd0,
        PH_HDR1 = 3'd1,
        PH_EXT  = 3'd2,
        PH_KEY  = 3'd3,
        PH_DATA = 3'd4
    } phase_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       has_byte;
        logic [1:0] frame_kind;
        logic [3:0] frame_opcode;
        logic       final_fragment;
        logic       last_of_frame;
    } result_t;

    function automatic logic [1:0] kind_of(input logic [3:0] op);
        logic [1:0] k;
        unique case (op)
            OP_TEXT:  k = KIND_TEXT;
            OP_CLOSE: k = KIND_CLOSE;
            OP_PING:  k = KIND_PING;
            default:  k = KIND_OTHER;
        endcase
        return k;
    endfunction

endpackage

@@ src/wsdf_front.sv @@
// Header parser and unmasker: accepts one byte a beat and pushes results.
module wsdf_front
    import wsdf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] rx_byte,
    output logic       push,
    output result_t    push_data
);

    phase_t                   phase_reg, phase_next;
    logic [3:0]               ext_reg, ext_next;
    logic [LENGTH_BITS-1:0]   rem_reg, rem_next;
    logic [31:0]              key_reg, key_next;
    logic [1:0]               kpos_reg, kpos_next;
    logic [3:0]               op_reg, op_next;
    logic                     masked_reg, masked_next;
    logic                     fin_reg, fin_next;

    logic [6:0]               len7;
    logic [LENGTH_BITS-1:0]   len7_ext;
    logic [LENGTH_BITS-1:0]   ext_shift;
    logic [3:0]               ext_dec;
    logic [7:0]               key_byte;
    logic                     rem_zero;
    logic                     rem_le1;
    logic                     emit;
    logic                     emit_has;
    logic                     emit_last;

    assign len7     = rx_byte[6:0];
    assign len7_ext = {{(LENGTH_BITS-7){1'b0}}, len7};
    assign ext_dec  = ext_reg - 4'd1;
    assign rem_zero = (rem_reg == '0);
    assign rem_le1  = (rem_reg[LENGTH_BITS-1:1] == '0);

    always_comb
    begin
        if (rem_reg[LENGTH_BITS-1:LENGTH_BITS-8] != 8'd0)
        begin
            ext_shift = '1;
        end
        else
        begin
            ext_shift = {rem_reg[LENGTH_BITS-9:0], rx_byte};
        end
    end

    always_comb
    begin
        case (kpos_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
        if (!masked_reg)
        begin
            key_byte = 8'd0;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HDR1:
            begin
                if (len7 == LEN7_EXT16[6:0] || len7 == LEN7_EXT64[6:0])
                begin
                    phase_next = PH_EXT;
                end
                else if (rx_byte[7])
                begin
                    phase_next = PH_KEY;
                end
                else if (len7 == 7'd0)
                begin
                    phase_next = PH_HDR0;
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            PH_EXT:
            begin
                if (ext_dec == 4'd0)
                begin
                    if (masked_reg)
                    begin
                        phase_next = PH_KEY;
                    end
                    else if (ext_shift == '0)
                    begin
                        phase_next = PH_HDR0;
                    end
                    else
                    begin
                        phase_next = PH_DATA;
                    end
                end
            end
            PH_KEY:
            begin
                if (ext_dec == 4'd0)
                begin
                    phase_next = rem_zero ? PH_HDR0 : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (rem_le1)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                phase_next = PH_HDR1;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        ext_next    = ext_reg;
        rem_next    = rem_reg;
        key_next    = key_reg;
        kpos_next   = kpos_reg;
        op_next     = op_reg;
        masked_next = masked_reg;
        fin_next    = fin_reg;
        emit        = 1'b0;
        emit_has    = 1'b0;
        emit_last   = 1'b0;
        unique case (phase_reg)
            PH_HDR1:
            begin
                masked_next = rx_byte[7];
                key_next    = 32'd0;
                kpos_next   = 2'd0;
                if (len7 == LEN7_EXT16[6:0])
                begin
                    rem_next = '0;
                    ext_next = EXT16_BYTES;
                end
                else if (len7 == LEN7_EXT64[6:0])
                begin
                    rem_next = '0;
                    ext_next = EXT64_BYTES;
                end
                else
                begin
                    rem_next = len7_ext;
                    if (rx_byte[7])
                    begin
                        ext_next = KEY_BYTES;
                    end
                    else if (len7 == 7'd0)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                end
            end
            PH_EXT:
            begin
                rem_next = ext_shift;
                ext_next = ext_dec;
                if (ext_dec == 4'd0)
                begin
                    kpos_next = 2'd0;
                    if (masked_reg)
                    begin
                        ext_next = KEY_BYTES;
                    end
                    else if (ext_shift == '0)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                end
            end
            PH_KEY:
            begin
                key_next = {key_reg[23:0], rx_byte};
                ext_next = ext_dec;
                if (ext_dec == 4'd0)
                begin
                    kpos_next = 2'd0;
                    if (rem_zero)
                    begin
                        emit      = 1'b1;
                        emit_last = 1'b1;
                    end
                end
            end
            PH_DATA:
            begin
                kpos_next = kpos_reg + 2'd1;
                if (!rem_zero)
                begin
                    rem_next = rem_reg - LENGTH_BITS'(1);
                end
                emit      = 1'b1;
                emit_has  = 1'b1;
                emit_last = rem_le1;
            end
            default:
            begin
                fin_next  = rx_byte[7];
                op_next   = rx_byte[3:0];
                ext_next  = 4'd0;
                kpos_next = 2'd0;
            end
        endcase
    end

    assign push                     = accept && emit;
    assign push_data.payload_byte   = emit_has ? (rx_byte ^ key_byte) : 8'd0;
    assign push_data.has_byte       = emit_has;
    assign push_data.frame_kind     = kind_of(op_reg);
    assign push_data.frame_opcode   = op_reg;
    assign push_data.final_fragment = fin_reg;
    assign push_data.last_of_frame  = emit_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HDR0;
            ext_reg    <= 4'd0;
            rem_reg    <= '0;
            key_reg    <= 32'd0;
            kpos_reg   <= 2'd0;
            op_reg     <= 4'd0;
            masked_reg <= 1'b0;
            fin_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            ext_reg    <= ext_next;
            rem_reg    <= rem_next;
            key_reg    <= key_next;
            kpos_reg   <= kpos_next;
            op_reg     <= op_next;
            masked_reg <= masked_next;
            fin_reg    <= fin_next;
        end
    end

endmodule

@@ src/wsdf_queue.sv @@
// Short result queue between the parser and the output stage.
module wsdf_queue
    import wsdf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    not_empty,
    output logic    full,
    output result_t head
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

@@ src/wsdf_back.sv @@
// Output register stage: drains the queue onto the result channel.
module wsdf_back
    import wsdf_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    q_not_empty,
    input  result_t q_head,
    output logic    pop,
    output logic    out_valid,
    input  logic    out_stall,
    output result_t out_data
);

    logic    valid_reg, valid_next;
    result_t data_reg;
    logic    load;

    assign load      = !valid_reg || !out_stall;
    assign pop       = load && q_not_empty;
    assign valid_next = load ? q_not_empty : valid_reg;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            data_reg <= q_head;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

@@ src/websocket_frame_deframer.sv @@
// Top level: WebSocket frame deframer, one received byte per beat.
// Results pass the result queue, then the output register that drives out_valid.
// Throughput: one byte per cycle while in_stall is low; the parser updates its state once per byte.
// in_stall rises only while the result queue is full (output side stalled).
// Reset is asynchronous, active low: parser returns to the first header byte,
// queue and output register empty.
module websocket_frame_deframer
    import wsdf_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] payload_byte,
    output logic       has_byte,
    output logic [1:0] frame_kind,
    output logic [3:0] frame_opcode,
    output logic       final_fragment,
    output logic       last_of_frame
);

    logic    accept;
    logic    push;
    result_t push_data;
    logic    q_full;
    logic    q_not_empty;
    result_t q_head;
    logic    pop;
    result_t out_data;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;

    wsdf_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .rx_byte   (rx_byte),
        .push      (push),
        .push_data (push_data)
    );

    wsdf_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (q_head)
    );

    wsdf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_head      (q_head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    assign payload_byte   = out_data.payload_byte;
    assign has_byte       = out_data.has_byte;
    assign frame_kind     = out_data.frame_kind;
    assign frame_opcode   = out_data.frame_opcode;
    assign final_fragment = out_data.final_fragment;
    assign last_of_frame  = out_data.last_of_frame;

endmodule

@@ src/wsdf_checker.sv @@
// Port-level checks for the deframer, bound to the top level.
module wsdf_checker
    import wsdf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] payload_byte,
    input logic       has_byte,
    input logic [1:0] frame_kind,
    input logic [3:0] frame_opcode,
    input logic       final_fragment,
    input logic       last_of_frame
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result beat dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(payload_byte) && $stable(has_byte)
            && $stable(last_of_frame) && $stable(frame_opcode)
            && $stable(final_fragment))
        else $error("result beat changed while stalled");

    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !has_byte |-> last_of_frame && payload_byte == 8'd0)
        else $error("end marker malformed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> frame_kind == kind_of(frame_opcode))
        else $error("frame kind does not match opcode");

    a_kind_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last_of_frame ##1 out_valid
            |-> $stable(frame_opcode) && $stable(final_fragment))
        else $error("frame tags changed inside a frame");

endmodule

bind websocket_frame_deframer wsdf_checker u_wsdf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .payload_byte   (payload_byte),
    .has_byte       (has_byte),
    .frame_kind     (frame_kind),
    .frame_opcode   (frame_opcode),
    .final_fragment (final_fragment),
    .last_of_frame  (last_of_frame)
);

@@ sim/tb_websocket_frame_deframer.sv @@
`timescale 1ns / 1ps
// Self-checking WebSocket frame deframer bench: directed, random, then a saturated-length frame.
module tb_websocket_frame_deframer;
    import wsdf_pkg::*;

    localparam logic [63:0] LEN_MAX = {64{1'b1}} >> (64 - LENGTH_BITS_DEF);
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_BYTES = 640;
    localparam int N_DIRECTED = 26;
    localparam int N_DIRECTED_FRAMES = 5;

    typedef struct packed {
        logic [7:0] b;
        logic       typed;
        result_t    want;
    } stim_row_t;

    localparam result_t NO_RESULT = '0;

    localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h81, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, 1'b0, KIND_TEXT, OP_TEXT, 1'b1, 1'b1}},
        '{8'h88, 1'b0, NO_RESULT},
        '{8'h81, 1'b0, NO_RESULT},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'hA5, 1'b0, NO_RESULT},
        '{8'h5A, 1'b0, NO_RESULT},
        '{8'h3C, 1'b1, '{8'hC3, 1'b1, KIND_CLOSE, OP_CLOSE, 1'b1, 1'b1}},
        '{8'h09, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, 1'b0, KIND_PING, OP_PING, 1'b0, 1'b1}},
        '{8'hFF, 1'b0, NO_RESULT},
        '{8'h7E, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h01, 1'b0, NO_RESULT},
        '{8'hFF, 1'b1, '{8'hFF, 1'b1, KIND_OTHER, 4'hF, 1'b1, 1'b1}},
        '{8'h70, 1'b0, NO_RESULT},
        '{8'h7F, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b0, NO_RESULT},
        '{8'h00, 1'b1, '{8'h00, 1'b0, KIND_OTHER, 4'h0, 1'b0, 1'b1}}
    };

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] payload_byte;
    logic       has_byte;
    logic [1:0] frame_kind;
    logic [3:0] frame_opcode;
    logic       final_fragment;
    logic       last_of_frame;

    phase_t      parse_st = PH_HDR0;
    logic [3:0]  ext_left = '0;
    logic [63:0] rem_len = '0;
    logic [31:0] key_word = '0;
    logic [1:0]  key_idx = '0;
    logic [3:0]  cur_op = '0;
    logic        masked = 1'b0;
    logic        fin = 1'b0;

    result_t expected_results[$];
    result_t head_result;

    int error_count = 0;
    int bytes_sent = 0;
    int frames_sent = 0;
    int beats_checked = 0;
    int markers_checked = 0;
    int send_idle_pct = 34;
    int recv_idle_pct = 34;
    int quiet_cycles = 0;

    websocket_frame_deframer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .rx_byte        (rx_byte),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .payload_byte   (payload_byte),
        .has_byte       (has_byte),
        .frame_kind     (frame_kind),
        .frame_opcode   (frame_opcode),
        .final_fragment (final_fragment),
        .last_of_frame  (last_of_frame)
    );

    always #5 clk = ~clk;

    function automatic frame_kind_t opcode_kind(input logic [3:0] op);
        frame_kind_t k;
        case (op)
            OP_TEXT:  k = KIND_TEXT;
            OP_CLOSE: k = KIND_CLOSE;
            OP_PING:  k = KIND_PING;
            default:  k = KIND_OTHER;
        endcase
        return k;
    endfunction

    function automatic bit deframe_byte(input logic [7:0] b, output result_t r);
        bit         len_known;
        bit         hdr_known;
        bit         got;
        logic [7:0] key_b;
        len_known = 1'b0;
        hdr_known = 1'b0;
        got = 1'b0;
        r = '0;
        case (parse_st)
            PH_HDR1:
            begin
                masked = b[7];
                key_word = '0;
                rem_len = '0;
                if (b[6:0] == LEN7_EXT16[6:0])
                begin
                    parse_st = PH_EXT;
                    ext_left = EXT16_BYTES;
                end
                else if (b[6:0] == LEN7_EXT64[6:0])
                begin
                    parse_st = PH_EXT;
                    ext_left = EXT64_BYTES;
                end
                else
                begin
                    rem_len = 64'(b[6:0]);
                    len_known = 1'b1;
                end
            end
            PH_EXT:
            begin
                if (rem_len > (LEN_MAX >> 8))
                    rem_len = LEN_MAX;
                else
                    rem_len = {rem_len[55:0], b};
                if (rem_len > LEN_MAX)
                    rem_len = LEN_MAX;
                ext_left = ext_left - 4'd1;
                len_known = (ext_left == 4'd0);
            end
            PH_KEY:
            begin
                key_word = {key_word[23:0], b};
                ext_left = ext_left - 4'd1;
                hdr_known = (ext_left == 4'd0);
            end
            PH_DATA:
            begin
                key_b = masked ? key_word[8 * (3 - int'(key_idx)) +: 8] : 8'h00;
                key_idx = key_idx + 2'd1;
                if (rem_len != 0)
                    rem_len = rem_len - 64'd1;
                got = 1'b1;
                r.payload_byte = b ^ key_b;
                r.has_byte = 1'b1;
                if (rem_len == 0)
                begin
                    parse_st = PH_HDR0;
                    r.last_of_frame = 1'b1;
                end
            end
            default:
            begin
                fin = b[7];
                cur_op = b[3:0];
                ext_left = '0;
                key_idx = '0;
                parse_st = PH_HDR1;
            end
        endcase
        if (len_known)
        begin
            if (masked)
            begin
                parse_st = PH_KEY;
                ext_left = KEY_BYTES;
            end
            else
                hdr_known = 1'b1;
        end
        if (hdr_known)
        begin
            key_idx = '0;
            if (rem_len == 0)
            begin
                parse_st = PH_HDR0;
                got = 1'b1;
                r.last_of_frame = 1'b1;
            end
            else
                parse_st = PH_DATA;
        end
        if (got)
        begin
            r.frame_kind = opcode_kind(cur_op);
            r.frame_opcode = cur_op;
            r.final_fragment = fin;
        end
        return got;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0h want %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic send_beat(input logic [7:0] b, input bit typed, input result_t want);
        result_t predicted;
        bit      got;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        do
            @(posedge clk);
        while (in_stall);
        got = deframe_byte(b, predicted);
        if (typed)
            expected_results.insert(expected_results.size(), want);
        else if (got)
            expected_results.insert(expected_results.size(), predicted);
        bytes_sent++;
    endtask

    task automatic send_frame(input bit rough);
        logic [3:0]  op;
        logic [7:0]  hdr0;
        logic [6:0]  len7;
        logic [63:0] len;
        logic [31:0] key;
        bit          mask;
        int          pick;
        int          n_ext;
        case ($urandom_range(5))
            0:       op = OP_TEXT;
            1:       op = OP_CLOSE;
            2:       op = OP_PING;
            3:       op = 4'h0;
            4:       op = 4'h2;
            default: op = 4'($urandom);
        endcase
        hdr0 = rough ? 8'($urandom) : {1'($urandom), 3'b000, op};
        mask = 1'($urandom);
        key = $urandom;
        pick = $urandom_range(99);
        if (pick < 80)
            len = 64'($urandom_range(12));
        else if (pick < 88)
            len = 64'($urandom_range(125));
        else if (pick < 95 && $urandom_range(9) == 0)
            len = 64'($urandom_range(300, 256));
        else
            len = 64'($urandom_range(20));
        n_ext = (pick < 88) ? 0 : ((pick < 95) ? 2 : 8);
        len7 = (n_ext == 0) ? len[6:0] : ((n_ext == 2) ? LEN7_EXT16[6:0] : LEN7_EXT64[6:0]);
        send_beat(hdr0, 1'b0, NO_RESULT);
        send_beat({mask, len7}, 1'b0, NO_RESULT);
        for (int i = n_ext - 1; i >= 0; i--)
            send_beat(len[8 * i +: 8], 1'b0, NO_RESULT);
        if (mask)
            for (int i = 3; i >= 0; i--)
                send_beat(key[8 * i +: 8], 1'b0, NO_RESULT);
        for (longint k = 0; k < len; k++)
            send_beat(8'($urandom), 1'b0, NO_RESULT);
        frames_sent++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("beat with nothing expected", payload_byte, 0);
                else
                begin
                    head_result = expected_results.pop_front();
                    if (payload_byte !== head_result.payload_byte)
                        report_mismatch("payload_byte", payload_byte, head_result.payload_byte);
                    if (has_byte !== head_result.has_byte)
                        report_mismatch("has_byte", has_byte, head_result.has_byte);
                    if (frame_kind !== head_result.frame_kind)
                        report_mismatch("frame_kind", frame_kind, head_result.frame_kind);
                    if (frame_opcode !== head_result.frame_opcode)
                        report_mismatch("frame_opcode", frame_opcode, head_result.frame_opcode);
                    if (final_fragment !== head_result.final_fragment)
                        report_mismatch("final_fragment", final_fragment,
                                        head_result.final_fragment);
                    if (last_of_frame !== head_result.last_of_frame)
                        report_mismatch("last_of_frame", last_of_frame,
                                        head_result.last_of_frame);
                    if (head_result.has_byte)
                        beats_checked++;
                    else
                        markers_checked++;
                end
            end
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("[%0t] no beat moved for %0d cycles", $realtime, quiet_cycles);
                $display("tb_websocket_frame_deframer NOT OK");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        bit drained;
        drained = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_beat(DIRECTED_ROWS[i].b, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
        frames_sent = N_DIRECTED_FRAMES;

        while (bytes_sent < N_DIRECTED + RANDOM_BYTES)
        begin
            if (bytes_sent >= 150 && bytes_sent < 300)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            else
            begin
                send_idle_pct = 34;
                recv_idle_pct = 34;
            end
            if (!drained && bytes_sent > 400)
            begin
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (expected_results.size() != 0);
                drained = 1'b1;
            end
            send_frame($urandom_range(4) == 0);
        end

        // saturated 64-bit length: the frame never ends, so it goes last
        send_beat(8'($urandom), 1'b0, NO_RESULT);
        send_beat({1'b1, LEN7_EXT64[6:0]}, 1'b0, NO_RESULT);
        for (int i = 0; i < 8; i++)
            send_beat(8'hFF, 1'b0, NO_RESULT);
        for (int i = 0; i < 4; i++)
            send_beat(8'($urandom), 1'b0, NO_RESULT);
        for (int i = 0; i < 16; i++)
            send_beat(8'($urandom), 1'b0, NO_RESULT);
        frames_sent++;

        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
        repeat (8) @(posedge clk);

        $display("Sent %0d stream bytes in %0d frames (directed, random, saturated length).",
                 bytes_sent, frames_sent);
        $display("Checked %0d payload beats and %0d empty-frame markers, %0d mismatches.",
                 beats_checked, markers_checked, error_count);
        if (error_count == 0)
            $display("tb_websocket_frame_deframer OK");
        else
            $display("tb_websocket_frame_deframer NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
src/wsdf_pkg.sv
src/wsdf_front.sv
src/wsdf_queue.sv
src/wsdf_back.sv
src/websocket_frame_deframer.sv
src/wsdf_checker.sv
sim/tb_websocket_frame_deframer.sv
